@@ sv/srtf_tick_scheduler_top_defines.svh @@
// Assertion macros shared by the checker of the tick scheduler.
// No dependencies; the including module must provide clk_i and rst_ni.
`ifndef SRTF_TICK_SCHEDULER_TOP_DEFINES_SVH
`define SRTF_TICK_SCHEDULER_TOP_DEFINES_SVH

// A property checked on every rising edge outside reset.
`define SRTF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// An implication checked on every rising edge outside reset.
`define SRTF_ASSERT_IMP(label, ante, cons, msg) \
  `SRTF_ASSERT(label, (ante) |-> (cons), msg)

`endif

@@ sv/srtf_ts_pkg.sv @@
// Types and constants of the shortest-remaining-time tick scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package srtf_ts_pkg;

  localparam int TIME_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int BURST_W = 8;
  localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_run;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ sv/srtf_tick_scheduler_top.sv @@
// Top level of the shortest-remaining-time-first tick scheduler.
// Depends on srtf_ts_pkg, srtf_ts_ctrl and srtf_ts_dp.
//
// Input channel (in_valid_i / in_stall_o): a request carries cmd_i and the
// load fields. A load request writes one slot's arrival time and burst and
// restarts time at zero and produces no result. A tick request scans all
// PROCS slots, runs the eligible one with least remaining work (lowest
// slot on ties) and produces one result.
// Output channel (out_valid_o / out_stall_i): one result per tick request.
// A tick passes through the cycle that accepts it, a scan state that reads
// each slot in turn from the slot memory, a drain state that compares the
// last read and an update state that writes back the decrement and loads
// the result register. A new tick is taken only after the update state of
// the last one has finished.
// A held result does not block loads; a further tick waits in its final
// cycle until the result register is free.
// Reset empties every slot and clears time; no clearing pass is needed, as
// a per-slot valid bit marks written slots. While the receiver stalls, the
// result is held unchanged.
module srtf_tick_scheduler_top #(
  parameter int PROCS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 cmd_i,
  input  logic [srtf_ts_pkg::SLOT_W-1:0]       slot_i,
  input  logic [srtf_ts_pkg::TIME_W-1:0]       arrival_time_i,
  input  logic [srtf_ts_pkg::BURST_W-1:0]      burst_time_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 run_valid_o,
  output logic [srtf_ts_pkg::SLOT_W-1:0]       run_slot_o,
  output logic                                 all_done_o,
  output logic [srtf_ts_pkg::TIME_W-1:0]       tick_time_o
);

  srtf_ts_pkg::dp_cmd_t dp_cmd;
  srtf_ts_pkg::dp_sts_t dp_sts;

  srtf_ts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .sts_i      (dp_sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (dp_cmd)
  );

  srtf_ts_dp #(
    .PROCS (PROCS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .slot_i         (slot_i),
    .arrival_time_i (arrival_time_i),
    .burst_time_i   (burst_time_i),
    .out_stall_i    (out_stall_i),
    .sts_o          (dp_sts),
    .out_valid_o    (out_valid_o),
    .run_valid_o    (run_valid_o),
    .run_slot_o     (run_slot_o),
    .all_done_o     (all_done_o),
    .tick_time_o    (tick_time_o)
  );

endmodule

@@ sv/srtf_ts_ctrl.sv @@
// Controller state machine of the tick scheduler.
// Depends on srtf_ts_pkg; drives the datapath through dp_cmd_t.
module srtf_ts_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 cmd_i,
  input  srtf_ts_pkg::dp_sts_t sts_i,
  output logic                 in_stall_o,
  output srtf_ts_pkg::dp_cmd_t cmd_o
);

  srtf_ts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srtf_ts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      srtf_ts_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (cmd_i == srtf_ts_pkg::CMD_TICK) begin
            cmd_o.scan_start = 1'b1;
            state_d          = srtf_ts_pkg::ST_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      srtf_ts_pkg::ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_last) begin
          state_d = srtf_ts_pkg::ST_DRAIN;
        end
      end
      // The last slot's read data is compared in this cycle.
      srtf_ts_pkg::ST_DRAIN: begin
        state_d = srtf_ts_pkg::ST_UPDATE;
      end
      srtf_ts_pkg::ST_UPDATE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = srtf_ts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srtf_ts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/srtf_ts_dp.sv @@
// Datapath of the tick scheduler: slot memories, scan unit, time counter
// and result register. Depends on srtf_ts_pkg; commanded by srtf_ts_ctrl.
module srtf_ts_dp #(
  parameter int PROCS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  srtf_ts_pkg::dp_cmd_t                 cmd_i,
  input  logic [srtf_ts_pkg::SLOT_W-1:0]       slot_i,
  input  logic [srtf_ts_pkg::TIME_W-1:0]       arrival_time_i,
  input  logic [srtf_ts_pkg::BURST_W-1:0]      burst_time_i,
  input  logic                                 out_stall_i,
  output srtf_ts_pkg::dp_sts_t                 sts_o,
  output logic                                 out_valid_o,
  output logic                                 run_valid_o,
  output logic [srtf_ts_pkg::SLOT_W-1:0]       run_slot_o,
  output logic                                 all_done_o,
  output logic [srtf_ts_pkg::TIME_W-1:0]       tick_time_o
);

  localparam int IDX_W   = $clog2(PROCS);
  localparam int SLOT_W  = srtf_ts_pkg::SLOT_W;
  localparam int TIME_W  = srtf_ts_pkg::TIME_W;
  localparam int BURST_W = srtf_ts_pkg::BURST_W;

  logic [TIME_W-1:0]  arr_mem [PROCS];
  logic [BURST_W-1:0] rem_mem [PROCS];
  logic [PROCS-1:0]   vld_q;

  logic [TIME_W-1:0]  time_q;
  logic [IDX_W-1:0]   cnt_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               rd_pend_q;
  logic [TIME_W-1:0]  arr_rd_q;
  logic [BURST_W-1:0] rem_rd_q;
  logic               vld_rd_q;

  logic               found_q, done_q;
  logic [IDX_W-1:0]   pick_q;
  logic [BURST_W-1:0] best_q;

  logic               out_valid_q;
  logic               run_valid_q, all_done_q;
  logic [SLOT_W-1:0]  run_slot_q;
  logic [TIME_W-1:0]  tick_time_q;

  logic               in_range;
  logic               load_wr;
  logic               rem_wr;
  logic [IDX_W-1:0]   wr_addr;
  logic [BURST_W-1:0] rem_wr_data;
  logic [BURST_W-1:0] rem_eff;
  logic               take;

  assign in_range    = (32'(slot_i) < PROCS);
  assign load_wr     = cmd_i.load && in_range;
  assign rem_wr      = load_wr || (cmd_i.commit && found_q);
  assign wr_addr     = cmd_i.load ? IDX_W'(slot_i) : pick_q;
  assign rem_wr_data = cmd_i.load ? burst_time_i : (best_q - 8'd1);

  // A slot never written reads as empty.
  assign rem_eff = vld_rd_q ? rem_rd_q : '0;
  assign take    = rd_pend_q && (rem_eff != '0) && (arr_rd_q <= time_q) &&
                   (!found_q || (rem_eff < best_q));

  assign sts_o.scan_last = (cnt_q == IDX_W'(PROCS - 1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      arr_mem[wr_addr] <= arrival_time_i;
    end
    if (rem_wr) begin
      rem_mem[wr_addr] <= rem_wr_data;
    end
    arr_rd_q <= arr_mem[cnt_q];
    rem_rd_q <= rem_mem[cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_rd_q  <= 1'b0;
      time_q    <= '0;
      cnt_q     <= '0;
      rd_idx_q  <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
      done_q    <= 1'b1;
      pick_q    <= '0;
      best_q    <= '0;
    end else begin
      vld_rd_q  <= vld_q[cnt_q];
      rd_idx_q  <= cnt_q;
      rd_pend_q <= cmd_i.scan_run;
      if (load_wr) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.load) begin
        time_q <= '0;
      end else if (cmd_i.commit && (time_q != srtf_ts_pkg::TIME_MAX)) begin
        time_q <= time_q + 16'd1;
      end
      if (cmd_i.scan_start) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
        done_q  <= 1'b1;
      end else begin
        if (cmd_i.scan_run) begin
          cnt_q <= cnt_q + IDX_W'(1);
        end
        if (rd_pend_q && (rem_eff != '0)) begin
          done_q <= 1'b0;
        end
        if (take) begin
          found_q <= 1'b1;
          pick_q  <= rd_idx_q;
          best_q  <= rem_eff;
        end
      end
    end
  end

  // Result register: holds a finished tick until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      run_valid_q <= found_q;
      run_slot_q  <= found_q ? SLOT_W'(pick_q) : '0;
      all_done_q  <= done_q;
      tick_time_q <= time_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign run_valid_o = run_valid_q;
  assign run_slot_o  = run_slot_q;
  assign all_done_o  = all_done_q;
  assign tick_time_o = tick_time_q;

endmodule

@@ sv/srtf_ts_chk.sv @@
// Port-level checker of the tick scheduler, bound to the top level.
// Depends on srtf_tick_scheduler_top_defines.svh for its assertion macros.
`include "srtf_tick_scheduler_top_defines.svh"

module srtf_ts_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        cmd_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        run_valid_o,
  input logic [3:0]  run_slot_o,
  input logic        all_done_o,
  input logic [15:0] tick_time_o
);

  logic tick_acc;
  assign tick_acc = in_valid_i && !in_stall_o && cmd_i;

  // A stalled result keeps its payload.
  `SRTF_ASSERT_IMP(a_out_hold, out_valid_o && out_stall_i,
    ##1 (out_valid_o && $stable(run_slot_o) && $stable(tick_time_o)),
    "stalled result changed")

  // An accepted tick is followed by a busy input channel.
  `SRTF_ASSERT_IMP(a_tick_busy, tick_acc, ##1 in_stall_o,
    "tick request not followed by a busy input channel")

  // An idle tick reports slot zero.
  `SRTF_ASSERT_IMP(a_idle_slot, out_valid_o && !run_valid_o, run_slot_o == 4'd0,
    "idle tick reports a non-zero slot")

  // When all work was done nothing can run.
  `SRTF_ASSERT_IMP(a_done_idle, out_valid_o && all_done_o, !run_valid_o,
    "process ran although all work was done")

endmodule

bind srtf_tick_scheduler_top srtf_ts_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .run_valid_o (run_valid_o),
  .run_slot_o  (run_slot_o),
  .all_done_o  (all_done_o),
  .tick_time_o (tick_time_o)
);
